### hdl/csma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csma_pkg;

  localparam logic [1:0] REQ_TX   = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_DONE = 2'd2;

  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_BUSY = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_WAIT = 2'd1;
  localparam logic [1:0] MODE_CONG = 2'd2;

  localparam logic [1:0] CFG_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_MIN      = 2'd1;
  localparam logic [1:0] CFG_INIT_MAX = 2'd2;
  localparam logic [1:0] CFG_CONG_MAX = 2'd3;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic        ResetEnable  = 1'b1;
  localparam logic [15:0] ResetMin     = 16'd320;
  localparam logic [15:0] ResetInitMax = 16'd4960;
  localparam logic [15:0] ResetCongMax = 16'd2240;

  typedef struct packed {
    logic       hold_len;
    logic       start_draw;
    logic       draw_cong;
    logic       draw_commit;
    logic       count_dec;
    logic       count_clr;
    logic       timer_clr;
    logic       mode_we;
    logic [1:0] mode_val;
    logic       res_load;
    logic [1:0] res_kind;
    logic       res_len_in;
    logic       res_len_held;
    logic       res_status;
  } cmd_t;

  typedef struct packed {
    logic       enable;
    logic [1:0] mode;
    logic       timer_running;
    logic       count_gt1;
    logic       div_done;
    logic       res_valid;
  } sts_t;

endpackage

`default_nettype wire

### hdl/csma_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface csma_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [6:0]  packet_length;
  logic        channel_clear;
  logic [31:0] random_word;
  logic [7:0]  done_status;

  modport source (
    output valid, req_type, packet_length, channel_clear, random_word, done_status,
    input  ready
  );
  modport sink (
    input  valid, req_type, packet_length, channel_clear, random_word, done_status,
    output ready
  );
endinterface

interface csma_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [6:0] out_length;
  logic [7:0] out_status;

  modport source (
    output valid, result_kind, out_length, out_status,
    input  ready
  );
  modport sink (
    input  valid, result_kind, out_length, out_status,
    output ready
  );
endinterface

`default_nettype wire

### hdl/csma_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module csma_dpath #(
  parameter int unsigned BACKOFF_WIDTH  = 16,
  parameter int unsigned MAX_PACKET_LEN = 127
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [csma_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [csma_pkg::CfgDataWidth-1:0]  cfg_data_i,
  input  logic [6:0]                         packet_length_i,
  input  logic [31:0]                        random_word_i,
  input  logic [7:0]                         done_status_i,
  input  logic                               res_ready_i,
  input  csma_pkg::cmd_t                     cmd_i,
  output csma_pkg::sts_t                     sts_o,
  output logic                               res_valid_o,
  output logic [1:0]                         result_kind_o,
  output logic [6:0]                         out_length_o,
  output logic [7:0]                         out_status_o
);
  import csma_pkg::*;

  localparam logic [7:0] MaxLen = 8'(MAX_PACKET_LEN);

  logic                     enable_q;
  logic [15:0]              min_q;
  logic [15:0]              init_max_q;
  logic [15:0]              cong_max_q;

  logic [1:0]               mode_q;
  logic [BACKOFF_WIDTH-1:0] count_q;
  logic [BACKOFF_WIDTH-1:0] count_d;
  logic                     timer_q;
  logic [6:0]               held_len_q;

  logic [31:0]              quo_q;
  logic [15:0]              rem_q;
  logic [15:0]              rem_d;
  logic [15:0]              span_q;
  logic                     empty_q;
  logic [4:0]               bit_cnt_q;
  logic                     div_busy_q;
  logic                     div_done_q;

  logic                     res_valid_q;
  logic [1:0]               res_kind_q;
  logic [6:0]               res_len_q;
  logic [7:0]               res_status_q;

  logic [6:0]               sat_len;
  logic [15:0]              draw_hi;
  logic [16:0]              trial;
  logic [16:0]              drawn_sum;

  assign sat_len = ({1'b0, packet_length_i} > MaxLen) ? MaxLen[6:0] : packet_length_i;
  assign draw_hi = cmd_i.draw_cong ? cong_max_q : init_max_q;

  // One quotient bit per cycle of restoring division; the remainder stays below the span when the span is nonzero.
  assign trial = {rem_q, quo_q[31]};
  assign rem_d = (trial >= {1'b0, span_q}) ? 16'(trial - {1'b0, span_q}) : trial[15:0];

  assign drawn_sum = empty_q ? {1'b0, min_q} : ({1'b0, min_q} + {1'b0, rem_q});

  always_comb begin
    count_d = count_q;
    if (cmd_i.draw_commit) begin
      count_d = BACKOFF_WIDTH'(drawn_sum);
    end else if (cmd_i.count_clr) begin
      count_d = '0;
    end else if (cmd_i.count_dec) begin
      count_d = count_q - BACKOFF_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= ResetEnable;
      min_q      <= ResetMin;
      init_max_q <= ResetInitMax;
      cong_max_q <= ResetCongMax;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE:   enable_q   <= cfg_data_i[0];
        CFG_MIN:      min_q      <= cfg_data_i;
        CFG_INIT_MAX: init_max_q <= cfg_data_i;
        CFG_CONG_MAX: cong_max_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      count_q <= '0;
      timer_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.mode_we) begin
        mode_q <= cmd_i.mode_val;
      end
      if (cmd_i.draw_commit) begin
        timer_q <= 1'b1;
      end else if (cmd_i.timer_clr) begin
        timer_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_len) begin
      held_len_q <= sat_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_done_q <= 1'b0;
      bit_cnt_q  <= '0;
    end else begin
      div_done_q <= 1'b0;
      if (cmd_i.start_draw) begin
        div_busy_q <= 1'b1;
        bit_cnt_q  <= '0;
      end else if (div_busy_q) begin
        bit_cnt_q <= bit_cnt_q + 5'd1;
        if (bit_cnt_q == 5'd31) begin
          div_busy_q <= 1'b0;
          div_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_draw) begin
      quo_q   <= random_word_i;
      rem_q   <= '0;
      span_q  <= draw_hi - min_q;
      empty_q <= (draw_hi <= min_q);
    end else if (div_busy_q) begin
      quo_q <= {quo_q[30:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_kind_q   <= cmd_i.res_kind;
      res_len_q    <= cmd_i.res_len_in ? sat_len :
                      (cmd_i.res_len_held ? held_len_q : 7'd0);
      res_status_q <= cmd_i.res_status ? done_status_i : 8'd0;
    end
  end

  assign sts_o.enable        = enable_q;
  assign sts_o.mode          = mode_q;
  assign sts_o.timer_running = timer_q;
  assign sts_o.count_gt1     = (count_q > BACKOFF_WIDTH'(1));
  assign sts_o.div_done      = div_done_q;
  assign sts_o.res_valid     = res_valid_q;

  assign res_valid_o   = res_valid_q;
  assign result_kind_o = res_kind_q;
  assign out_length_o  = res_len_q;
  assign out_status_o  = res_status_q;

endmodule

`default_nettype wire

### hdl/csma_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module csma_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     req_type_i,
  input  logic           channel_clear_i,
  input  logic           res_ready_i,
  input  csma_pkg::sts_t sts_i,
  output csma_pkg::cmd_t cmd_o
);
  import csma_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DRAW = 1'b1;

  logic state_q;
  logic state_d;
  logic in_fire;

  assign in_ready_o = (state_q == S_IDLE) && (!sts_i.res_valid || res_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    if (state_q == S_DRAW) begin
      if (sts_i.div_done) begin
        cmd_o.draw_commit = 1'b1;
        state_d           = S_IDLE;
      end
    end else if (in_fire) begin
      case (req_type_i)
        REQ_TX: begin
          if (!sts_i.enable) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_kind   = KIND_SEND;
            cmd_o.res_len_in = 1'b1;
          end else if (sts_i.mode != MODE_IDLE) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = KIND_BUSY;
          end else begin
            cmd_o.mode_we    = 1'b1;
            cmd_o.mode_val   = MODE_WAIT;
            cmd_o.hold_len   = 1'b1;
            cmd_o.start_draw = 1'b1;
            state_d          = S_DRAW;
          end
        end
        REQ_TICK: begin
          if (sts_i.timer_running) begin
            if (sts_i.count_gt1) begin
              cmd_o.count_dec = 1'b1;
            end else begin
              cmd_o.count_clr = 1'b1;
              if (channel_clear_i) begin
                cmd_o.timer_clr    = 1'b1;
                cmd_o.res_load     = 1'b1;
                cmd_o.res_kind     = KIND_SEND;
                cmd_o.res_len_held = 1'b1;
              end else if (sts_i.mode == MODE_WAIT) begin
                cmd_o.mode_we    = 1'b1;
                cmd_o.mode_val   = MODE_CONG;
                cmd_o.start_draw = 1'b1;
                cmd_o.draw_cong  = 1'b1;
                state_d          = S_DRAW;
              end else begin
                cmd_o.mode_we   = 1'b1;
                cmd_o.mode_val  = MODE_IDLE;
                cmd_o.timer_clr = 1'b1;
                cmd_o.res_load  = 1'b1;
                cmd_o.res_kind  = KIND_BUSY;
              end
            end
          end
        end
        REQ_DONE: begin
          cmd_o.mode_we    = sts_i.enable;
          cmd_o.mode_val   = MODE_IDLE;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_kind   = KIND_DONE;
          cmd_o.res_status = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_draw_enters_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_draw |=> (state_q == S_DRAW))
    else $error("backoff draw did not occupy the controller");

  a_done_only_in_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_DRAW))
    else $error("divider finished outside of a draw");

  a_result_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (in_valid_i && in_ready_o))
    else $error("result produced without an accepted item");

  a_commit_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.draw_commit |-> (sts_i.div_done && !cmd_o.res_load))
    else $error("backoff committed before the divider finished");

endmodule

`default_nettype wire

### hdl/csma_backoff_controller.sv
// Carrier-sense random backoff controller placed between an upper layer and a radio.
// Items arrive on the req channel: a transmit request, a microsecond tick carrying the
// channel assessment, or a transmit-done report from the radio. Each item yields zero
// or one result item on the res channel: send to radio, report busy, or report done.
// Configuration registers are written through cfg_we_i, cfg_idx_i and cfg_data_i;
// index 0 enables backoff, 1 to 3 set the minimum and both exclusive backoff bounds.
// The user must write them only while idle; the block does not enforce this.
// An item that needs no new backoff leaves the controller idle, and its result is
// valid in the cycle after it is accepted. An item that draws a backoff (a request
// that starts waiting, or a busy first expiry) reduces the random word modulo the
// span by a one-bit-per-cycle restoring divider of 32 steps, and req stays not ready
// until the new count is loaded.
// Reset clears the mode to idle, stops the timer, zeroes the count and restores the
// register defaults (enabled, 320, 4960, 2240).
// Results sit in an output register; while the receiver stalls, req is ready only if
// the waiting result is being taken in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module csma_backoff_controller #(
  parameter int unsigned BACKOFF_WIDTH  = 16,
  parameter int unsigned MAX_PACKET_LEN = 127
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [csma_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [csma_pkg::CfgDataWidth-1:0] cfg_data_i,
  csma_req_if.sink                          req,
  csma_res_if.source                        res
);
  import csma_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic res_valid;
  logic [1:0] result_kind;
  logic [6:0] out_length;
  logic [7:0] out_status;

  csma_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (req.valid),
    .in_ready_o      (in_ready),
    .req_type_i      (req.req_type),
    .channel_clear_i (req.channel_clear),
    .res_ready_i     (res.ready),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  csma_dpath #(
    .BACKOFF_WIDTH  (BACKOFF_WIDTH),
    .MAX_PACKET_LEN (MAX_PACKET_LEN)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .packet_length_i (req.packet_length),
    .random_word_i   (req.random_word),
    .done_status_i   (req.done_status),
    .res_ready_i     (res.ready),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .res_valid_o     (res_valid),
    .result_kind_o   (result_kind),
    .out_length_o    (out_length),
    .out_status_o    (out_status)
  );

  assign req.ready       = in_ready;
  assign res.valid       = res_valid;
  assign res.result_kind = result_kind;
  assign res.out_length  = out_length;
  assign res.out_status  = out_status;

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import csma_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  len;
    logic        clear;
    logic [31:0] rnd;
    logic [7:0]  status;
  } req_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] len;
    logic [7:0] status;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  csma_req_if req_if ();
  csma_res_if res_if ();

  csma_backoff_controller u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_if),
    .res        (res_if)
  );

  req_item_t   pending_reqs[$];
  result_t     due_results[$];
  req_item_t   drv_item;
  result_t     seen_result;
  int          mismatches;
  bit          idle_en;
  int          hold_trig;
  int          hold_seen;
  int          hold_cnt;
  int          tx_gap;
  int          rx_gap;

  logic        cur_en;
  logic [15:0] cur_min;
  logic [15:0] cur_init_max;
  logic [15:0] cur_cong_max;
  logic [1:0]  bo_mode;
  logic [15:0] bo_count;
  logic        bo_timer;
  logic [6:0]  bo_len;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("csma_backoff_controller test failed");
    $finish;
  end

  function automatic logic [15:0] draw_count(logic [15:0] lo, logic [15:0] hi,
                                             logic [31:0] rnd);
    logic [31:0] span;
    logic [31:0] sum;
    span = {16'd0, hi} - {16'd0, lo};
    sum  = {16'd0, lo} + (rnd % span);
    if (hi <= lo) begin
      draw_count = lo;
    end else begin
      draw_count = sum[15:0];
    end
  endfunction

  task automatic predict_backoff_step(req_item_t it);
    result_t r;
    bit      hit;
    r   = '0;
    hit = 1'b0;
    case (it.req_type)
      REQ_TX: begin
        if (!cur_en) begin
          r.kind = KIND_SEND;
          r.len  = it.len;
          hit    = 1'b1;
        end else if (bo_mode != MODE_IDLE) begin
          r.kind = KIND_BUSY;
          hit    = 1'b1;
        end else begin
          bo_mode  = MODE_WAIT;
          bo_len   = it.len;
          bo_count = draw_count(cur_min, cur_init_max, it.rnd);
          bo_timer = 1'b1;
        end
      end
      REQ_TICK: begin
        if (bo_timer) begin
          if (bo_count > 16'd1) begin
            bo_count = bo_count - 16'd1;
          end else begin
            bo_count = 16'd0;
            if (it.clear) begin
              bo_timer = 1'b0;
              r.kind   = KIND_SEND;
              r.len    = bo_len;
              hit      = 1'b1;
            end else if (bo_mode == MODE_WAIT) begin
              bo_mode  = MODE_CONG;
              bo_count = draw_count(cur_min, cur_cong_max, it.rnd);
            end else begin
              bo_mode  = MODE_IDLE;
              bo_timer = 1'b0;
              r.kind   = KIND_BUSY;
              hit      = 1'b1;
            end
          end
        end
      end
      REQ_DONE: begin
        if (cur_en) begin
          bo_mode = MODE_IDLE;
        end
        r.kind   = KIND_DONE;
        r.status = it.status;
        hit      = 1'b1;
      end
      default: begin
      end
    endcase
    if (hit) begin
      due_results.push_back(r);
    end
  endtask

  task automatic flag_result(string why, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected kind %0d len %0d status %0d, got kind %0d len %0d status %0d",
               why, want.kind, want.len, want.status, got.kind, got.len, got.status);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        seen_result.kind   = res_if.result_kind;
        seen_result.len    = res_if.out_length;
        seen_result.status = res_if.out_status;
        if (due_results.size() == 0) begin
          flag_result("no result expected", '0, seen_result);
        end else if (seen_result.kind !== due_results[0].kind ||
                     seen_result.len !== due_results[0].len ||
                     seen_result.status !== due_results[0].status) begin
          flag_result("wrong field", due_results[0], seen_result);
          void'(due_results.pop_front());
        end else begin
          void'(due_results.pop_front());
        end
      end
      if (req_if.valid && req_if.ready) begin
        drv_item.req_type = req_if.req_type;
        drv_item.len      = req_if.packet_length;
        drv_item.clear    = req_if.channel_clear;
        drv_item.rnd      = req_if.random_word;
        drv_item.status   = req_if.done_status;
        predict_backoff_step(drv_item);
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      tx_gap       <= 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (tx_gap != 0) begin
        tx_gap       <= tx_gap - 1;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req_if.req_type      <= pending_reqs[0].req_type;
        req_if.packet_length <= pending_reqs[0].len;
        req_if.channel_clear <= pending_reqs[0].clear;
        req_if.random_word   <= pending_reqs[0].rnd;
        req_if.done_status   <= pending_reqs[0].status;
        req_if.valid         <= 1'b1;
        void'(pending_reqs.pop_front());
        if (idle_en && $urandom_range(0, 9) == 0) begin
          tx_gap <= $urandom_range(1, 12);
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      rx_gap       <= 0;
      hold_cnt     <= 0;
      hold_seen    <= 0;
    end else if (hold_seen != hold_trig) begin
      hold_seen    <= hold_trig;
      hold_cnt     <= 400;
      res_if.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt     <= hold_cnt - 1;
      res_if.ready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap       <= rx_gap - 1;
      res_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 15) < 2) begin
      rx_gap       <= $urandom_range(0, 11);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic queue_item(logic [1:0] kind, logic [6:0] len, logic clear,
                            logic [31:0] rnd, logic [7:0] status);
    req_item_t it;
    it.req_type = kind;
    it.len      = len;
    it.clear    = clear;
    it.rnd      = rnd;
    it.status   = status;
    pending_reqs.push_back(it);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_ENABLE:   cur_en       = val[0];
      CFG_MIN:      cur_min      = val;
      CFG_INIT_MAX: cur_init_max = val;
      default:      cur_cong_max = val;
    endcase
  endtask

  task automatic set_config(logic en, logic [15:0] lo, logic [15:0] init_max,
                            logic [15:0] cong_max);
    write_cfg(CFG_ENABLE, {15'd0, en});
    write_cfg(CFG_MIN, lo);
    write_cfg(CFG_INIT_MAX, init_max);
    write_cfg(CFG_CONG_MAX, cong_max);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A backoff draw keeps the block busy with no result to show for it.
  task automatic drain;
    while (pending_reqs.size() != 0 || req_if.valid || due_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (50) @(posedge clk_i);
  endtask

  task automatic gen_traffic(int n_items, int span);
    int         made;
    int         ticks;
    logic [1:0] kind;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 99) < 75) begin
        queue_item(REQ_TX, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                   $urandom, 8'($urandom_range(0, 255)));
        ticks = $urandom_range(1, span);
        repeat (ticks) begin
          queue_item(REQ_TICK, 7'($urandom_range(0, 127)), $urandom_range(0, 3) != 0,
                     $urandom, 8'($urandom_range(0, 255)));
        end
        made += ticks + 1;
        if ($urandom_range(0, 4) != 0) begin
          queue_item(REQ_DONE, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                     $urandom, 8'($urandom_range(0, 255)));
          made++;
        end
      end else begin
        kind = 2'($urandom_range(0, 3));
        queue_item(kind, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                   $urandom, 8'($urandom_range(0, 255)));
        if (kind != REQ_UNUSED) begin
          made++;
        end
      end
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_ENABLE;
    cfg_data_i           = '0;
    req_if.valid         = 1'b0;
    req_if.req_type      = REQ_TX;
    req_if.packet_length = '0;
    req_if.channel_clear = 1'b0;
    req_if.random_word   = '0;
    req_if.done_status   = '0;
    res_if.ready         = 1'b0;
    mismatches           = 0;
    idle_en              = 1'b1;
    hold_trig            = 0;
    cur_en               = ResetEnable;
    cur_min              = ResetMin;
    cur_init_max         = ResetInitMax;
    cur_cong_max         = ResetCongMax;
    bo_mode              = MODE_IDLE;
    bo_count             = '0;
    bo_timer             = 1'b0;
    bo_len               = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(1'b1, 16'd2, 16'd6, 16'd4);
    queue_item(REQ_TICK, 7'd0, 1'b1, 32'd0, 8'd0);
    queue_item(REQ_UNUSED, 7'd127, 1'b1, 32'hFFFF_FFFF, 8'hFF);
    queue_item(REQ_DONE, 7'd0, 1'b0, 32'd0, 8'hFF);
    queue_item(REQ_TX, 7'd127, 1'b0, 32'hFFFF_FFFF, 8'd0);
    queue_item(REQ_TX, 7'd0, 1'b0, 32'd0, 8'd0);
    repeat (4) queue_item(REQ_TICK, 7'd0, 1'b0, 32'd0, 8'd0);
    queue_item(REQ_TICK, 7'd0, 1'b1, 32'd0, 8'd0);
    queue_item(REQ_DONE, 7'd0, 1'b0, 32'd0, 8'd0);
    queue_item(REQ_TX, 7'd1, 1'b0, 32'd0, 8'd0);
    queue_item(REQ_TICK, 7'd0, 1'b0, 32'd0, 8'd0);
    queue_item(REQ_TICK, 7'd0, 1'b0, 32'd1, 8'd0);
    queue_item(REQ_TICK, 7'd0, 1'b1, 32'd0, 8'd0);
    queue_item(REQ_TICK, 7'd0, 1'b1, 32'd0, 8'd0);
    queue_item(REQ_TICK, 7'd0, 1'b0, 32'd0, 8'd0);
    queue_item(REQ_TX, 7'd85, 1'b0, 32'd0, 8'd0);
    queue_item(REQ_DONE, 7'd0, 1'b0, 32'd0, 8'h5A);
    queue_item(REQ_TICK, 7'd0, 1'b0, 32'd0, 8'd0);
    queue_item(REQ_TICK, 7'd0, 1'b0, 32'd0, 8'd0);
    queue_item(REQ_TX, 7'd42, 1'b0, 32'd0, 8'd0);
    queue_item(REQ_DONE, 7'd0, 1'b0, 32'd0, 8'hA5);
    queue_item(REQ_TX, 7'd99, 1'b0, 32'd3, 8'd0);
    repeat (6) queue_item(REQ_TICK, 7'd0, 1'b1, 32'd0, 8'd0);
    queue_item(REQ_DONE, 7'd0, 1'b0, 32'd0, 8'd1);
    drain();

    set_config(1'b0, 16'd2, 16'd6, 16'd4);
    queue_item(REQ_TX, 7'd42, 1'b1, 32'd5, 8'd0);
    queue_item(REQ_DONE, 7'd0, 1'b0, 32'd0, 8'h80);
    queue_item(REQ_TICK, 7'd0, 1'b1, 32'd0, 8'd0);
    drain();

    set_config(1'b1, 16'd0, 16'd0, 16'hFFFF);
    queue_item(REQ_TX, 7'd127, 1'b0, 32'd9, 8'd0);
    queue_item(REQ_TICK, 7'd0, 1'b0, 32'hFFFF_FFFF, 8'd0);
    queue_item(REQ_TICK, 7'd0, 1'b0, 32'd0, 8'd0);
    queue_item(REQ_TX, 7'd0, 1'b0, 32'd0, 8'd0);
    queue_item(REQ_TICK, 7'd0, 1'b1, 32'd0, 8'd0);
    queue_item(REQ_DONE, 7'd0, 1'b0, 32'd0, 8'd0);
    drain();

    set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_item(REQ_TX, 7'd64, 1'b0, 32'hFFFF_FFFF, 8'd0);
    queue_item(REQ_TICK, 7'd0, 1'b0, 32'd0, 8'd0);
    queue_item(REQ_TICK, 7'd0, 1'b1, 32'd0, 8'd0);
    queue_item(REQ_DONE, 7'd0, 1'b0, 32'd0, 8'h7F);
    drain();

    set_config(1'b1, 16'd0, 16'hFFFF, 16'd0);
    queue_item(REQ_TX, 7'd33, 1'b0, 32'hFFFF_FFFE, 8'd0);
    queue_item(REQ_DONE, 7'd0, 1'b0, 32'd0, 8'd2);
    drain();

    set_config(1'b1, 16'd1, 16'd9, 16'd5);
    gen_traffic(260, 20);
    drain();

    set_config(1'b1, 16'd0, 16'd16, 16'd3);
    gen_traffic(260, 36);
    hold_trig++;
    drain();

    set_config(1'b0, 16'd2, 16'd5, 16'd5);
    gen_traffic(260, 12);
    drain();

    set_config(1'b1, 16'd6, 16'd3, 16'd12);
    gen_traffic(260, 28);
    drain();

    idle_en = 1'b0;
    set_config(1'b1, 16'd3, 16'd8, 16'd0);
    gen_traffic(260, 20);
    drain();

    if (mismatches == 0) begin
      $display("csma_backoff_controller test passed");
    end else begin
      $display("csma_backoff_controller test failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/csma_pkg.sv
hdl/csma_if.sv
hdl/csma_dpath.sv
hdl/csma_ctrl.sv
hdl/csma_backoff_controller.sv
tb/sv/tb_top.sv
